FILE: src/sml_pkg.sv
// Package for the substring match locator: payload types, register codes, constants.
package sml_pkg;

  localparam int unsigned NeedleMaxBytes  = 16;
  localparam int unsigned IndexBits       = 17;
  localparam int unsigned CountBits       = 16;
  localparam int unsigned PosFieldBits    = 16;
  localparam int unsigned LenBits         = 5;
  localparam int unsigned CfgDataBits     = 64;
  localparam int unsigned CfgIndexBits    = 2;
  localparam int unsigned DefMaxNeedle    = 16;
  localparam int unsigned DefPositionBits = 16;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_NEEDLE_LOW  = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] haystack_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic                    match_ends_here;
    logic [CountBits-1:0]    match_count;
    logic                    first_found;
    logic [PosFieldBits-1:0] first_position;
    logic [PosFieldBits-1:0] last_position;
    logic                    haystack_done;
  } out_beat_t;

endpackage

FILE: src/sml_match.sv
// Window compare: newest len bytes of the window against the needle.
module sml_match
  import sml_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE = DefMaxNeedle
) (
  input  logic [MAX_NEEDLE-1:0][7:0]         window,
  input  logic [NeedleMaxBytes-1:0][7:0]     needle,
  input  logic [LenBits-1:0]                 len,
  output logic                               hit
);

  logic [MAX_NEEDLE-1:0] lane_ok;

  // Newest byte (lane 0) pairs with needle byte len-1.
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      logic [LenBits-1:0] nidx;
      nidx = len - LenBits'(i) - LenBits'(1);
      if (LenBits'(i) < len) begin
        lane_ok[i] = (window[i] == needle[nidx[3:0]]);
      end else begin
        lane_ok[i] = 1'b1;
      end
    end
  end

  assign hit = &lane_ok;

endmodule

FILE: src/substring_match_locator_unit.sv
// Top level of the streaming substring match locator.
//
// Usage:
//   Haystack bytes enter on the in_* channel (valid/ready), one byte per beat;
//   final_byte marks the last byte of a haystack. Each input beat yields exactly
//   one result beat on out_* : whether a needle occurrence ends at this byte,
//   the saturating occurrence count and the earliest/latest start positions.
//   The needle (up to 16 bytes, byte 0 first) and its length are set through cfg_*;
//   the user must do so only while the block is idle; the block does not enforce it.
// Timing / throughput:
//   The result beat is registered in the cycle after its input beat is taken; one
//   beat per cycle sustained while out_ready is high. The rate is set by the single
//   compare stage before the result register; in_ready follows out_ready when held.
// Reset:
//   rst clears the window, counters and positions and sets needle length 1.
//   After a final_byte beat the per-haystack state returns to its reset value
//   (needle registers are kept).
// Stall:
//   While out_valid is high and out_ready low, the result holds and no input
//   beat is taken.
module substring_match_locator_unit
  import sml_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE    = DefMaxNeedle,
  parameter int unsigned POSITION_BITS = DefPositionBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_beat_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_beat_t               out_data,
  input  logic                    cfg_we,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data
);

  // Start positions saturate at 2^POSITION_BITS-1 (no effect at 17 bits and up).
  localparam logic [IndexBits-1:0] PosMax =
      (POSITION_BITS >= IndexBits) ? {IndexBits{1'b1}}
                                   : IndexBits'((64'd1 << POSITION_BITS) - 64'd1);
  localparam logic [IndexBits-1:0] IndexMax = {IndexBits{1'b1}};
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // configuration registers
  logic [CfgDataBits-1:0] needle_low;
  logic [CfgDataBits-1:0] needle_high;
  logic [LenBits-1:0]     needle_length;

  // per-haystack state
  logic [MAX_NEEDLE-1:0][7:0] recent_bytes;
  logic [IndexBits-1:0]       byte_index;
  logic [CountBits-1:0]       occurrence_count;
  logic                       seen_any;
  logic [PosFieldBits-1:0]    earliest_start;
  logic [PosFieldBits-1:0]    latest_start;

  logic [MAX_NEEDLE-1:0][7:0] recent_bytes_next;
  logic [IndexBits-1:0]       byte_index_next;
  logic [CountBits-1:0]       occurrence_count_next;
  logic                       seen_any_next;
  logic [PosFieldBits-1:0]    earliest_start_next;
  logic [PosFieldBits-1:0]    latest_start_next;

  logic                       in_fire;
  logic [LenBits-1:0]         len;
  logic                       window_hit;
  logic                       hit;
  logic [IndexBits-1:0]       start_raw;
  logic [PosFieldBits-1:0]    start_pos;
  logic [NeedleMaxBytes-1:0][7:0] needle;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign needle   = {needle_high, needle_low};

  // Config write port; out-of-range index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low    <= '0;
      needle_high   <= '0;
      needle_length <= LenBits'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEEDLE_LOW:  needle_low    <= cfg_data;
        REG_NEEDLE_HIGH: needle_high   <= cfg_data;
        REG_NEEDLE_LEN:  needle_length <= cfg_data[LenBits-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as 1, clamp to window depth.
  always_comb begin
    if (needle_length == '0) begin
      len = LenBits'(1);
    end else if (needle_length > LenBits'(MAX_NEEDLE)) begin
      len = LenBits'(MAX_NEEDLE);
    end else begin
      len = needle_length;
    end
  end

  // Shift new byte into lane 0.
  always_comb begin
    recent_bytes_next[0] = in_data.haystack_byte;
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      recent_bytes_next[i] = recent_bytes[i-1];
    end
  end

  assign byte_index_next = (byte_index == IndexMax) ? byte_index
                                                    : byte_index + IndexBits'(1);

  sml_match #(
    .MAX_NEEDLE(MAX_NEEDLE)
  ) u_match (
    .window(recent_bytes_next),
    .needle(needle),
    .len   (len),
    .hit   (window_hit)
  );

  // A hit needs at least len bytes in this haystack.
  assign hit       = window_hit && (byte_index_next >= IndexBits'(len));
  assign start_raw = byte_index_next - IndexBits'(len);
  assign start_pos = (start_raw > PosMax) ? PosMax[PosFieldBits-1:0]
                                          : start_raw[PosFieldBits-1:0];

  always_comb begin
    occurrence_count_next = occurrence_count;
    seen_any_next         = seen_any;
    earliest_start_next   = earliest_start;
    latest_start_next     = latest_start;
    if (hit) begin
      if (occurrence_count != CountMax) begin
        occurrence_count_next = occurrence_count + CountBits'(1);
      end
      if (!seen_any) begin
        earliest_start_next = start_pos;
      end
      latest_start_next = start_pos;
      seen_any_next     = 1'b1;
    end
  end

  // State update; final byte returns the state to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes     <= '0;
      byte_index       <= '0;
      occurrence_count <= '0;
      seen_any         <= 1'b0;
      earliest_start   <= '0;
      latest_start     <= '0;
    end else if (in_fire) begin
      if (in_data.final_byte) begin
        recent_bytes     <= '0;
        byte_index       <= '0;
        occurrence_count <= '0;
        seen_any         <= 1'b0;
        earliest_start   <= '0;
        latest_start     <= '0;
      end else begin
        recent_bytes     <= recent_bytes_next;
        byte_index       <= byte_index_next;
        occurrence_count <= occurrence_count_next;
        seen_any         <= seen_any_next;
        earliest_start   <= earliest_start_next;
        latest_start     <= latest_start_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Positions stay zero until the first hit, so no masking is needed here.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.match_ends_here <= hit;
      out_data.match_count     <= occurrence_count_next;
      out_data.first_found     <= seen_any_next;
      out_data.first_position  <= earliest_start_next;
      out_data.last_position   <= latest_start_next;
      out_data.haystack_done   <= in_data.final_byte;
    end
  end

  // Assertions
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.match_ends_here |->
      out_data.first_found && (out_data.match_count != '0))
    else $error("hit reported without count or first_found");

  a_none_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.first_found |->
      (out_data.match_count == '0) && (out_data.first_position == '0) &&
      (out_data.last_position == '0))
    else $error("fields nonzero before any occurrence");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.final_byte |=>
      (byte_index == '0) && !seen_any && (occurrence_count == '0))
    else $error("state not cleared after final beat");

  a_one_result_per_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

endmodule
